@@ src/bba_pkg.sv @@
// Shared types, codes and defaults for the buddy block allocator.
`default_nettype none

package bba_pkg;

    localparam int LAYERS_DEF = 8;
    localparam int TREES_DEF  = 4;
    localparam int LYW        = 4;   // wide enough for any depth up to 16 levels
    localparam int RSW        = 6;
    localparam int OFFW       = 48;
    localparam int IDXW       = 7;

    typedef enum logic [1:0] {
        ND_ABSENT = 2'd0,
        ND_FREE   = 2'd1,
        ND_ALLOC  = 2'd2,
        ND_SPLIT  = 2'd3
    } t_node;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        AS_SELF   = 2'd0,
        AS_BUDDY  = 2'd1,
        AS_PARENT = 2'd2,
        AS_RCHILD = 2'd3
    } t_asel;

    typedef enum logic [2:0] {
        HO_HOLD   = 3'd0,
        HO_PARENT = 3'd1,
        HO_LCHILD = 3'd2,
        HO_SCAN   = 3'd3,
        HO_FIRST  = 3'd4
    } t_hop;

    typedef enum logic [1:0] {
        FO_HOLD = 2'd0,
        FO_DEC  = 2'd1,
        FO_INC  = 2'd2
    } t_fop;

    typedef struct packed {
        logic    capture;
        logic    clr_step;
        logic    rd;
        t_asel   rd_sel;
        logic    wr;
        t_asel   wr_sel;
        t_node   wr_data;
        logic    wr_dec;
        t_hop    h_op;
        t_fop    f_op;
        logic    scan_start;
        logic    open_tree;
        logic    out_load;
        t_status out_status;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic kind_free;
        logic lay_bad;
        logic free_bad;
        logic rd_is_alloc;
        logic rd_is_free;
        logic h_is_root;
        logic cnt_nz;
        logic from_zero;
        logic from_at_lay;
        logic trees_full;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

@@ src/bba_datapath.sv @@
// Datapath: node status memory, free counters, walk registers and result word.
`default_nettype none

module bba_datapath #(
    parameter int LAYERS = bba_pkg::LAYERS_DEF,
    parameter int TREES  = bba_pkg::TREES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_kind,
    input  wire logic [2:0]               i_layer,
    input  wire logic [1:0]               i_tree_sel,
    input  wire logic [6:0]               i_block_index,
    input  wire logic                     i_cfg_we,
    input  wire logic [bba_pkg::RSW-1:0]  i_cfg_data,
    input  wire bba_pkg::t_cmd            i_cmd,
    output bba_pkg::t_stat                o_stat,
    input  wire logic                     i_stall,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [1:0]                    o_tree_out,
    output logic [bba_pkg::IDXW-1:0]      o_index_out,
    output logic [bba_pkg::OFFW-1:0]      o_byte_offset,
    output logic                          o_opened_tree
);

    localparam int TW  = (TREES > 1) ? $clog2(TREES) : 1;
    localparam int TCW = $clog2(TREES + 1);
    localparam int AW  = TW + LAYERS;
    localparam int CW  = $clog2((TREES << (LAYERS - 1)) + 1);
    localparam int LYW = bba_pkg::LYW;

    logic                     r_kind;
    logic [2:0]               r_lay;
    logic [1:0]               r_tsel;
    logic [6:0]               r_bidx;
    logic [LYW-1:0]           r_from;
    logic [LAYERS-1:0]        r_h;
    logic [TW-1:0]            r_tree;
    logic [TCW-1:0]           r_trees;
    logic                     r_opened;
    bba_pkg::t_node           r_rd;
    logic [AW-1:0]            r_clr;
    logic [bba_pkg::RSW-1:0]  r_rsl;
    logic [CW-1:0]            r_fcnt [LAYERS];
    bba_pkg::t_node           r_mem [2**AW];

    logic                     r_ov;
    logic [1:0]               r_ostat;
    logic [1:0]               r_otree;
    logic [bba_pkg::IDXW-1:0] r_oidx;
    logic [bba_pkg::OFFW-1:0] r_ooff;
    logic                     r_oopen;

    logic [LAYERS-1:0] h_buddy, h_parent, h_rchild, h_inc, h_shift, h_first;
    logic [LAYERS-1:0] rd_node, wr_node;
    logic [LYW-1:0]    wr_lay;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic              wr_en;
    bba_pkg::t_node    wr_val;
    logic [15:0]       cap_h;
    logic              scan_last;
    logic              cnt_nz;
    logic [LAYERS-1:0] pos;
    logic [63:0]       off64;
    logic [15:0]       pos16, tree16;
    logic [5:0]        lay6;

    assign h_buddy  = r_h ^ LAYERS'(1);
    assign h_parent = r_h >> 1;
    assign h_rchild = (r_h << 1) | LAYERS'(1);
    assign h_inc    = r_h + LAYERS'(1);
    assign h_shift  = h_inc >> r_from;
    assign h_first  = LAYERS'(1) << r_from;
    // Stepping past the last block of a layer clears the layer's leading bit.
    assign scan_last = !h_shift[0];
    assign cap_h    = (16'(1) << i_layer) | 16'(i_block_index);

    always_comb begin
        case (i_cmd.rd_sel)
            bba_pkg::AS_BUDDY:  rd_node = h_buddy;
            bba_pkg::AS_PARENT: rd_node = h_parent;
            bba_pkg::AS_RCHILD: rd_node = h_rchild;
            default:            rd_node = r_h;
        endcase
        case (i_cmd.wr_sel)
            bba_pkg::AS_BUDDY: begin
                wr_node = h_buddy;
                wr_lay  = r_from;
            end
            bba_pkg::AS_PARENT: begin
                wr_node = h_parent;
                wr_lay  = r_from - LYW'(1);
            end
            bba_pkg::AS_RCHILD: begin
                wr_node = h_rchild;
                wr_lay  = r_from + LYW'(1);
            end
            default: begin
                wr_node = r_h;
                wr_lay  = r_from;
            end
        endcase
    end

    assign rd_addr = {r_tree, rd_node};
    assign wr_en   = i_cmd.clr_step || i_cmd.wr;
    assign wr_addr = i_cmd.clr_step ? r_clr : {r_tree, wr_node};
    assign wr_val  = i_cmd.clr_step ? bba_pkg::ND_ABSENT : i_cmd.wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_val;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_comb begin
        cnt_nz = 1'b0;
        for (int g = 0; g < LAYERS; g++) begin
            if (r_from == LYW'(g)) begin
                cnt_nz = (r_fcnt[g] != '0);
            end
        end
    end

    always_comb begin
        o_stat.clr_done    = &r_clr;
        o_stat.kind_free   = r_kind;
        o_stat.lay_bad     = int'(r_lay) >= LAYERS;
        o_stat.free_bad    = (int'(r_lay) >= LAYERS) || (int'(r_tsel) >= int'(r_trees))
                             || ((r_bidx >> r_lay) != 7'd0);
        o_stat.rd_is_alloc = (r_rd == bba_pkg::ND_ALLOC);
        o_stat.rd_is_free  = (r_rd == bba_pkg::ND_FREE);
        o_stat.h_is_root   = (r_h == LAYERS'(1));
        o_stat.cnt_nz      = cnt_nz;
        o_stat.from_zero   = (r_from == '0);
        o_stat.from_at_lay = (r_from == LYW'(r_lay));
        o_stat.trees_full  = int'(r_trees) >= TREES;
        o_stat.out_busy    = r_ov && i_stall;
    end

    // Clear counter, open-tree count, root size register and free counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_trees <= '0;
            r_rsl   <= bba_pkg::RSW'(20);
            for (int g = 0; g < LAYERS; g++) begin
                r_fcnt[g] <= '0;
            end
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_we) begin
                r_rsl <= i_cfg_data;
            end
            if (i_cmd.open_tree) begin
                r_trees <= r_trees + TCW'(1);
            end
            for (int g = 0; g < LAYERS; g++) begin
                if (i_cmd.wr && wr_lay == LYW'(g)) begin
                    if (i_cmd.wr_data == bba_pkg::ND_FREE) begin
                        r_fcnt[g] <= r_fcnt[g] + CW'(1);
                    end else if (i_cmd.wr_dec) begin
                        r_fcnt[g] <= r_fcnt[g] - CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_lay    <= i_layer;
            r_tsel   <= i_tree_sel;
            r_bidx   <= i_block_index;
            r_from   <= LYW'(i_layer);
            r_h      <= cap_h[LAYERS-1:0];
            r_tree   <= TW'(i_tree_sel);
            r_opened <= 1'b0;
        end else begin
            case (i_cmd.f_op)
                bba_pkg::FO_DEC: r_from <= r_from - LYW'(1);
                bba_pkg::FO_INC: r_from <= r_from + LYW'(1);
                default:         r_from <= r_from;
            endcase
            if (i_cmd.open_tree) begin
                r_tree   <= TW'(r_trees);
                r_h      <= LAYERS'(1);
                r_opened <= 1'b1;
            end else begin
                case (i_cmd.h_op)
                    bba_pkg::HO_PARENT: r_h <= h_parent;
                    bba_pkg::HO_LCHILD: r_h <= r_h << 1;
                    bba_pkg::HO_FIRST:  r_h <= h_first;
                    bba_pkg::HO_SCAN: begin
                        if (scan_last) begin
                            r_h    <= h_first;
                            r_tree <= r_tree + TW'(1);
                        end else begin
                            r_h <= h_inc;
                        end
                    end
                    default: r_h <= r_h;
                endcase
                if (i_cmd.scan_start) begin
                    r_tree <= '0;
                end
            end
        end
    end

    // Result word.
    assign pos    = r_h ^ (LAYERS'(1) << r_lay);
    assign pos16  = 16'(pos);
    assign tree16 = 16'(r_tree);
    assign lay6   = {3'b000, r_lay};

    always_comb begin
        if (r_rsl >= lay6) begin
            off64 = 64'(pos) << (r_rsl - lay6);
        end else begin
            off64 = 64'(pos) >> (lay6 - r_rsl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ostat <= i_cmd.out_status;
            if (!r_kind && i_cmd.out_status == bba_pkg::ST_OK) begin
                r_otree <= tree16[1:0];
                r_oidx  <= pos16[bba_pkg::IDXW-1:0];
                r_ooff  <= off64[bba_pkg::OFFW-1:0];
                r_oopen <= r_opened;
            end else begin
                r_otree <= '0;
                r_oidx  <= '0;
                r_ooff  <= '0;
                r_oopen <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_status      = r_ostat;
    assign o_tree_out    = r_otree;
    assign o_index_out   = r_oidx;
    assign o_byte_offset = r_ooff;
    assign o_opened_tree = r_oopen;

endmodule

`default_nettype wire

@@ src/bba_ctrl.sv @@
// Controller: sequences clearing, allocation search and split, and free with merge.
`default_nettype none

module bba_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire bba_pkg::t_stat i_stat,
    output bba_pkg::t_cmd       o_cmd
);

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_DISP    = 14'b00000000000100,
        S_F_CHK   = 14'b00000000001000,
        S_M_RD    = 14'b00000000010000,
        S_M_CHK   = 14'b00000000100000,
        S_M_W2    = 14'b00000001000000,
        S_M_W3    = 14'b00000010000000,
        S_A_LAY   = 14'b00000100000000,
        S_S_RD    = 14'b00001000000000,
        S_S_CHK   = 14'b00010000000000,
        S_SPLIT   = 14'b00100000000000,
        S_SPLIT_R = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } t_state;

    t_state           r_state, n_state;
    logic             r_pend, n_pend;
    bba_pkg::t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_pend   <= 1'b0;
            r_status <= bba_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_status <= n_status;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_pend   = r_pend;
        n_status = r_status;
        o_cmd    = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.kind_free) begin
                    if (i_stat.free_bad) begin
                        n_status = bba_pkg::ST_BADFREE;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.rd     = 1'b1;
                        o_cmd.rd_sel = bba_pkg::AS_SELF;
                        n_state      = S_F_CHK;
                    end
                end else if (i_stat.lay_bad) begin
                    n_status = bba_pkg::ST_NOSPACE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_A_LAY;
                end
            end
            S_F_CHK: begin
                if (!i_stat.rd_is_alloc) begin
                    n_status = bba_pkg::ST_BADFREE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.wr      = 1'b1;
                    o_cmd.wr_sel  = bba_pkg::AS_SELF;
                    o_cmd.wr_data = bba_pkg::ND_FREE;
                    n_state       = S_M_RD;
                end
            end
            S_M_RD: begin
                if (i_stat.h_is_root) begin
                    n_status = bba_pkg::ST_OK;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = bba_pkg::AS_BUDDY;
                    n_state      = S_M_CHK;
                end
            end
            S_M_CHK: begin
                if (!i_stat.rd_is_free) begin
                    n_status = bba_pkg::ST_OK;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.wr      = 1'b1;
                    o_cmd.wr_sel  = bba_pkg::AS_SELF;
                    o_cmd.wr_data = bba_pkg::ND_ABSENT;
                    o_cmd.wr_dec  = 1'b1;
                    n_state       = S_M_W2;
                end
            end
            S_M_W2: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_sel  = bba_pkg::AS_BUDDY;
                o_cmd.wr_data = bba_pkg::ND_ABSENT;
                o_cmd.wr_dec  = 1'b1;
                n_state       = S_M_W3;
            end
            S_M_W3: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_sel  = bba_pkg::AS_PARENT;
                o_cmd.wr_data = bba_pkg::ND_FREE;
                o_cmd.h_op    = bba_pkg::HO_PARENT;
                o_cmd.f_op    = bba_pkg::FO_DEC;
                n_state       = S_M_RD;
            end
            S_A_LAY: begin
                if (i_stat.cnt_nz) begin
                    o_cmd.h_op       = bba_pkg::HO_FIRST;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_S_RD;
                end else if (i_stat.from_zero) begin
                    if (i_stat.trees_full) begin
                        n_status = bba_pkg::ST_NOSPACE;
                        n_state  = S_DONE;
                    end else begin
                        // A fresh root was never counted as free, so no decrement.
                        o_cmd.open_tree = 1'b1;
                        n_pend          = 1'b0;
                        n_state         = S_SPLIT;
                    end
                end else begin
                    o_cmd.f_op = bba_pkg::FO_DEC;
                end
            end
            S_S_RD: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = bba_pkg::AS_SELF;
                n_state      = S_S_CHK;
            end
            S_S_CHK: begin
                if (i_stat.rd_is_free) begin
                    n_pend  = 1'b1;
                    n_state = S_SPLIT;
                end else begin
                    o_cmd.h_op = bba_pkg::HO_SCAN;
                    n_state    = S_S_RD;
                end
            end
            S_SPLIT: begin
                o_cmd.wr     = 1'b1;
                o_cmd.wr_sel = bba_pkg::AS_SELF;
                o_cmd.wr_dec = r_pend;
                n_pend       = 1'b0;
                if (i_stat.from_at_lay) begin
                    o_cmd.wr_data = bba_pkg::ND_ALLOC;
                    n_status      = bba_pkg::ST_OK;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.wr_data = bba_pkg::ND_SPLIT;
                    n_state       = S_SPLIT_R;
                end
            end
            S_SPLIT_R: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_sel  = bba_pkg::AS_RCHILD;
                o_cmd.wr_data = bba_pkg::ND_FREE;
                o_cmd.h_op    = bba_pkg::HO_LCHILD;
                o_cmd.f_op    = bba_pkg::FO_INC;
                n_state       = S_SPLIT;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_status;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/buddy_block_allocator_unit.sv @@
// Top level of the buddy block allocator: controller plus datapath.
//
//   channel   direction  handshake           word
//   request   in         i_valid / o_stall   i_kind, i_layer, i_tree_sel, i_block_index
//   result    out        o_valid / i_stall   o_status, o_tree_out, o_index_out,
//                                            o_byte_offset, o_opened_tree
//   config    in         i_cfg_we            i_cfg_data (root_size_log2)
//
// One request is worked at a time. A free checks the block, then merges level by level
// while the buddy is free, up to the root at most; a rejected free ends after the check.
// Allocate searches layers upward, scans nodes and splits down level by level; a rejected
// allocate ends early, or after the search when all trees are full.
// After reset a clearing pass over all 2^(clog2(TREES)+LAYERS) node entries (1024 by default)
// runs before the first request is taken; a held result keeps the next one from finishing.
`default_nettype none

module buddy_block_allocator_unit #(
    parameter int LAYERS = bba_pkg::LAYERS_DEF,
    parameter int TREES  = bba_pkg::TREES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_kind,
    input  wire logic [2:0]               i_layer,
    input  wire logic [1:0]               i_tree_sel,
    input  wire logic [6:0]               i_block_index,
    input  wire logic                     i_cfg_we,
    input  wire logic [bba_pkg::RSW-1:0]  i_cfg_data,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [1:0]                    o_status,
    output logic [1:0]                    o_tree_out,
    output logic [bba_pkg::IDXW-1:0]      o_index_out,
    output logic [bba_pkg::OFFW-1:0]      o_byte_offset,
    output logic                          o_opened_tree
);

    bba_pkg::t_cmd  w_cmd;
    bba_pkg::t_stat w_stat;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    bba_datapath #(
        .LAYERS (LAYERS),
        .TREES  (TREES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kind        (i_kind),
        .i_layer       (i_layer),
        .i_tree_sel    (i_tree_sel),
        .i_block_index (i_block_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_tree_out    (o_tree_out),
        .o_index_out   (o_index_out),
        .o_byte_offset (o_byte_offset),
        .o_opened_tree (o_opened_tree)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted but block did not go busy");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !(w_cmd.wr || w_cmd.clr_step))
        else $error("node memory written while idle");

    a_fail_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != bba_pkg::ST_OK) |->
            (o_opened_tree == 1'b0 && o_byte_offset == '0 && o_index_out == '0))
        else $error("failed request carries a nonzero result word");
`endif

endmodule

`default_nettype wire

@@ tb/tb_buddy_block_allocator_unit.sv @@
// Self-checking testbench for the buddy block allocator: directed table, register extremes, then random traffic.
`timescale 1ns / 1ps

module tb_buddy_block_allocator_unit;

    localparam int LAYERS = bba_pkg::LAYERS_DEF;
    localparam int TREES = bba_pkg::TREES_DEF;
    localparam int NODES = 1 << LAYERS;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [2:0] layer;
        logic [1:0] tree_sel;
        logic [6:0] block_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  tree_out;
        logic [6:0]  index_out;
        logic [47:0] byte_offset;
        logic        opened_tree;
    } t_rsp;

    typedef struct packed {
        logic [1:0] tree;
        logic [2:0] layer;
        logic [6:0] index;
    } t_blk;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_kind = 1'b0;
    logic [2:0] i_layer = '0;
    logic [1:0] i_tree_sel = '0;
    logic [6:0] i_block_index = '0;
    logic i_cfg_we = 1'b0;
    logic [bba_pkg::RSW-1:0] i_cfg_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_status;
    logic [1:0] o_tree_out;
    logic [bba_pkg::IDXW-1:0] o_index_out;
    logic [bba_pkg::OFFW-1:0] o_byte_offset;
    logic o_opened_tree;

    buddy_block_allocator_unit #(.LAYERS(LAYERS), .TREES(TREES)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_layer(i_layer), .i_tree_sel(i_tree_sel),
        .i_block_index(i_block_index), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_tree_out(o_tree_out), .o_index_out(o_index_out),
        .o_byte_offset(o_byte_offset), .o_opened_tree(o_opened_tree)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state.
    bba_pkg::t_node node_map [TREES][NODES];
    int unsigned open_trees;
    logic [5:0] root_log2;
    t_rsp expected_rsps[$];
    t_blk live_blocks[$];
    int mismatches = 0;
    longint cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;

    function automatic logic [47:0] block_offset(int lay, int pos);
        logic [63:0] v;
        v = 64'(pos);
        if (root_log2 >= lay) v = v << (root_log2 - lay);
        else v = v >> (lay - root_log2);
        return v[47:0];
    endfunction

    function automatic bit lowest_free(int lay, output int t, output int p);
        int cnt;
        cnt = 1 << lay;
        for (int tt = 0; tt < open_trees; tt++)
            for (int i = 0; i < cnt; i++)
                if (node_map[tt][cnt + i] == bba_pkg::ND_FREE) begin
                    t = tt;
                    p = i;
                    return 1'b1;
                end
        return 1'b0;
    endfunction

    function automatic t_rsp allocator_step(t_req r);
        t_rsp o;
        int lay, from, t, p, h;
        bit hit;
        o = '0;
        lay = int'(r.layer);
        t = 0;
        p = 0;
        if (r.kind == KIND_FREE) begin
            if (lay >= LAYERS || r.tree_sel >= open_trees || r.block_index >= (1 << lay)) begin
                o.status = bba_pkg::ST_BADFREE;
                return o;
            end
            h = (1 << lay) + int'(r.block_index);
            if (node_map[r.tree_sel][h] != bba_pkg::ND_ALLOC) begin
                o.status = bba_pkg::ST_BADFREE;
                return o;
            end
            node_map[r.tree_sel][h] = bba_pkg::ND_FREE;
            while (h > 1 && node_map[r.tree_sel][h ^ 1] == bba_pkg::ND_FREE) begin
                node_map[r.tree_sel][h] = bba_pkg::ND_ABSENT;
                node_map[r.tree_sel][h ^ 1] = bba_pkg::ND_ABSENT;
                h = h >> 1;
                node_map[r.tree_sel][h] = bba_pkg::ND_FREE;
            end
            return o;
        end
        if (lay >= LAYERS) begin
            o.status = bba_pkg::ST_NOSPACE;
            return o;
        end
        from = lay;
        hit = lowest_free(lay, t, p);
        while (!hit && from > 0) begin
            from--;
            hit = lowest_free(from, t, p);
        end
        if (!hit) begin
            if (open_trees >= TREES) begin
                o.status = bba_pkg::ST_NOSPACE;
                return o;
            end
            t = open_trees;
            open_trees++;
            node_map[t][1] = bba_pkg::ND_FREE;
            from = 0;
            p = 0;
            o.opened_tree = 1'b1;
        end
        h = (1 << from) + p;
        while (from < lay) begin
            node_map[t][h] = bba_pkg::ND_SPLIT;
            node_map[t][2 * h + 1] = bba_pkg::ND_FREE;
            h = h << 1;
            from++;
            p = p << 1;
        end
        node_map[t][h] = bba_pkg::ND_ALLOC;
        o.status = bba_pkg::ST_OK;
        o.tree_out = 2'(t);
        o.index_out = 7'(p);
        o.byte_offset = block_offset(lay, p);
        return o;
    endfunction

    // Sends one word; expected result is computed when the word is accepted.
    task automatic send_word(t_req r, bit typed, t_rsp want);
        t_rsp pred;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= r.kind;
        i_layer <= r.layer;
        i_tree_sel <= r.tree_sel;
        i_block_index <= r.block_index;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = allocator_step(r);
        if (typed && pred != want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row disagrees with predictor: %h vs %h", want, pred);
        end
        expected_rsps.insert(expected_rsps.size(), pred);
        if (r.kind == KIND_ALLOC && pred.status == bba_pkg::ST_OK)
            live_blocks.insert(live_blocks.size(),
                               {pred.tree_out, r.layer, pred.index_out});
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_root_log2(logic [5:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        root_log2 = v;
    endtask

    task automatic random_word();
        t_req r;
        int k;
        r = 13'($urandom);
        k = $urandom_range(99);
        if (k < 45) begin
            r.kind = KIND_ALLOC;
            r.layer = 3'($urandom_range(7));
        end else if (k < 85 && live_blocks.size() != 0) begin
            int j;
            j = $urandom_range(live_blocks.size() - 1);
            r.kind = KIND_FREE;
            r.tree_sel = live_blocks[j].tree;
            r.layer = live_blocks[j].layer;
            r.block_index = live_blocks[j].index;
            live_blocks.delete(j);
        end
        send_word(r, 1'b0, '0);
    endtask

    // Result side: random stall, optional long hold-off, in-order compare.
    always @(posedge i_clk) begin
        t_rsp got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_status, o_tree_out, o_index_out, o_byte_offset, o_opened_tree};
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
            end else begin
                want = expected_rsps.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h got %h", want, got);
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_buddy_block_allocator_unit: errors");
            $finish;
        end
    end

    t_req dir_req [$];
    t_rsp dir_rsp [$];
    bit dir_typed [$];

    task automatic row(logic k, int lay, int ts, int bi, bit typed, t_rsp w);
        dir_req.insert(dir_req.size(), {k, lay[2:0], ts[1:0], bi[6:0]});
        dir_rsp.insert(dir_rsp.size(), w);
        dir_typed.insert(dir_typed.size(), typed);
    endtask

    initial begin
        t_rsp bad, full;
        bad = '0;
        bad.status = bba_pkg::ST_BADFREE;
        full = '0;
        full.status = bba_pkg::ST_NOSPACE;
        for (int t = 0; t < TREES; t++)
            for (int n = 0; n < NODES; n++) node_map[t][n] = bba_pkg::ND_ABSENT;
        open_trees = 0;
        root_log2 = 20;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: a bad free before any tree is open, then fills, merges and more bad frees.
        row(KIND_FREE, 0, 0, 0, 1, bad);
        row(KIND_ALLOC, 7, 3, 127, 1, {bba_pkg::ST_OK, 2'd0, 7'd0, 48'd0, 1'b1});
        row(KIND_ALLOC, 7, 0, 0, 1, {bba_pkg::ST_OK, 2'd0, 7'd1, 48'd8192, 1'b0});
        row(KIND_FREE, 7, 0, 0, 0, '0);
        row(KIND_FREE, 7, 0, 0, 1, bad);
        row(KIND_FREE, 3, 0, 9, 1, bad);
        row(KIND_FREE, 7, 2, 5, 1, bad);
        row(KIND_FREE, 7, 0, 1, 0, '0);
        row(KIND_ALLOC, 0, 0, 0, 1, {bba_pkg::ST_OK, 2'd0, 7'd0, 48'd0, 1'b0});
        row(KIND_ALLOC, 0, 0, 0, 1, {bba_pkg::ST_OK, 2'd1, 7'd0, 48'd0, 1'b1});
        row(KIND_ALLOC, 0, 0, 0, 1, {bba_pkg::ST_OK, 2'd2, 7'd0, 48'd0, 1'b1});
        row(KIND_ALLOC, 0, 0, 0, 1, {bba_pkg::ST_OK, 2'd3, 7'd0, 48'd0, 1'b1});
        row(KIND_ALLOC, 0, 0, 0, 1, full);
        row(KIND_ALLOC, 7, 0, 0, 1, full);
        row(KIND_FREE, 0, 3, 0, 0, '0);
        row(KIND_ALLOC, 1, 0, 0, 0, '0);
        row(KIND_ALLOC, 2, 0, 0, 0, '0);
        row(KIND_FREE, 1, 3, 0, 0, '0);
        row(KIND_FREE, 2, 3, 2, 0, '0);
        row(KIND_FREE, 0, 3, 0, 1, bad);
        for (int i = 0; i < dir_req.size(); i++) send_word(dir_req[i], dir_typed[i], dir_rsp[i]);
        drain();

        // Register extremes with small, tiny and huge trees.
        write_root_log2(6'd0);
        for (int i = 0; i < 3; i++) send_word({KIND_ALLOC, 3'd7, 2'd0, 7'd0}, 1'b0, '0);
        drain();
        write_root_log2(6'd63);
        for (int i = 0; i < 3; i++) send_word({KIND_ALLOC, 3'd1, 2'd0, 7'd0}, 1'b0, '0);
        drain();
        write_root_log2(6'd48);

        // Long receiver hold-off while words keep coming.
        hold_off = 400;
        for (int i = 0; i < 30; i++) random_word();
        drain();

        send_idle_pct = 9;
        recv_idle_pct = 69;
        for (int i = 0; i < 600; i++) random_word();
        drain();
        write_root_log2(6'd3);
        send_idle_pct = 69;
        recv_idle_pct = 9;
        for (int i = 0; i < 600; i++) random_word();
        drain();
        write_root_log2(6'($urandom_range(63)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 650; i++) random_word();
        drain();

        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("tb_buddy_block_allocator_unit: clean");
        else
            $display("tb_buddy_block_allocator_unit: errors");
        $finish;
    end
endmodule

@@ filelist.f @@
src/bba_pkg.sv
src/bba_datapath.sv
src/bba_ctrl.sv
src/buddy_block_allocator_unit.sv
tb/tb_buddy_block_allocator_unit.sv
